>>> rtl/spmd_pkg.sv
// spmd_pkg: shared constants for the segment pair distance block
// no dependencies; used by spmd_merge and the top level
package spmd_pkg;

   // one lane per endpoint-to-segment query
   localparam int NUM_LANES = 4;

   // lane roles, by index into the lane array
   localparam int LANE_A1_TO_B = 0;
   localparam int LANE_A2_TO_B = 1;
   localparam int LANE_B1_TO_A = 2;
   localparam int LANE_B2_TO_A = 3;

endpackage

>>> rtl/segment_pair_min_distance_sq.sv
// segment_pair_min_distance_sq: top level, four lanes, merge and valid pipeline
// depends on spmd_pkg, spmd_lane, spmd_div and spmd_merge
//
// Usage:
//   Request channel (req_*) carries one word: the endpoints of segments A and B
//   as signed COORD_BITS coordinates. Response channel (rsp_*) returns one word
//   per request: the smallest squared distance from an endpoint of either
//   segment to the other segment, truncated, 2*COORD_BITS+1 bits unsigned.
//   Segments that cross are not reported as zero.
//   Four lanes compute the endpoint-to-segment distances side by side; each
//   lane ends in a divider that resolves one quotient bit per stage.
//   A word passes the lane stages, the divider, the lane output register and
//   the merge levels before rsp_valid rises.
//   Throughput: one word per cycle while rsp_stall is low.
//   When the receiver holds rsp_stall with a word pending, the whole pipeline
//   freezes and req_stall rises; rsp_min_dist_sq holds steady.
//   Reset (synchronous, active high) clears all valid flags; the data
//   registers are not reset.
module segment_pair_min_distance_sq #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_start_x,
   input  logic signed [COORD_BITS-1:0] req_a_start_y,
   input  logic signed [COORD_BITS-1:0] req_a_end_x,
   input  logic signed [COORD_BITS-1:0] req_a_end_y,
   input  logic signed [COORD_BITS-1:0] req_b_start_x,
   input  logic signed [COORD_BITS-1:0] req_b_start_y,
   input  logic signed [COORD_BITS-1:0] req_b_end_x,
   input  logic signed [COORD_BITS-1:0] req_b_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2*COORD_BITS:0]        rsp_min_dist_sq
);

   localparam int DB  = 2 * COORD_BITS + 1;
   localparam int LAT = DB + 9;

   logic          en;
   logic [LAT-1:0] vld_ff;
   logic [DB-1:0] lane_dist [spmd_pkg::NUM_LANES];

   // global advance: freeze only while a finished word is held
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   // valid flags follow the data through every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // segment B against endpoints of A
   spmd_lane #(.COORD_BITS(COORD_BITS)) u_lane_a1 (
      .clock (clock), .en (en),
      .sx (req_b_start_x), .sy (req_b_start_y), .ex (req_b_end_x), .ey (req_b_end_y),
      .px (req_a_start_x), .py (req_a_start_y),
      .dist_sq (lane_dist[spmd_pkg::LANE_A1_TO_B])
   );
   spmd_lane #(.COORD_BITS(COORD_BITS)) u_lane_a2 (
      .clock (clock), .en (en),
      .sx (req_b_start_x), .sy (req_b_start_y), .ex (req_b_end_x), .ey (req_b_end_y),
      .px (req_a_end_x), .py (req_a_end_y),
      .dist_sq (lane_dist[spmd_pkg::LANE_A2_TO_B])
   );

   // segment A against endpoints of B
   spmd_lane #(.COORD_BITS(COORD_BITS)) u_lane_b1 (
      .clock (clock), .en (en),
      .sx (req_a_start_x), .sy (req_a_start_y), .ex (req_a_end_x), .ey (req_a_end_y),
      .px (req_b_start_x), .py (req_b_start_y),
      .dist_sq (lane_dist[spmd_pkg::LANE_B1_TO_A])
   );
   spmd_lane #(.COORD_BITS(COORD_BITS)) u_lane_b2 (
      .clock (clock), .en (en),
      .sx (req_a_start_x), .sy (req_a_start_y), .ex (req_a_end_x), .ey (req_a_end_y),
      .px (req_b_end_x), .py (req_b_end_y),
      .dist_sq (lane_dist[spmd_pkg::LANE_B2_TO_A])
   );

   // minimum over the four lanes
   spmd_merge #(.DIST_BITS(DB)) u_merge (
      .clock     (clock),
      .en        (en),
      .lane_dist (lane_dist),
      .best      (rsp_min_dist_sq)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_min_dist_sq))
      else $error("held response word changed");
   a_entry_tracked: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted word lost at pipeline entry");
   a_freeze_all: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved while frozen");
`endif

endmodule

>>> rtl/spmd_div.sv
// spmd_div: pipelined restoring divider, one quotient bit per stage
// carries the lane's case flag and fallback distance alongside; no package use
module spmd_div #(
   parameter int DIST_BITS = 33
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2*DIST_BITS-1:0]   num,
   input  logic [DIST_BITS-1:0]     den,
   input  logic                     interior,
   input  logic [DIST_BITS-1:0]     alt,
   output logic [DIST_BITS-1:0]     quo,
   output logic                     interior_out,
   output logic [DIST_BITS-1:0]     alt_out
);

   localparam int DB = DIST_BITS;

   logic [DB-1:0] rem_ff      [DB];
   logic [DB-1:0] low_ff      [DB];
   logic [DB-1:0] quo_ff      [DB];
   logic [DB-1:0] den_ff      [DB];
   logic          interior_ff [DB];
   logic [DB-1:0] alt_ff      [DB];

   for (genvar k = 0; k < DB; k++) begin : g_stage
      logic [DB-1:0] rem_cur, low_cur, quo_cur, den_cur, alt_cur;
      logic          interior_cur;
      logic [DB:0]   trial;
      logic          ge;
      logic [DB:0]   diff;
      logic [DB-1:0] rem_in;

      if (k == 0) begin : g_entry
         // entry: upper half is already below the divisor since the quotient fits
         always_comb begin
            rem_cur      = num[2*DB-1:DB];
            low_cur      = num[DB-1:0];
            quo_cur      = '0;
            den_cur      = den;
            interior_cur = interior;
            alt_cur      = alt;
         end
      end else begin : g_chain
         // later stages take the previous stage's registers
         always_comb begin
            rem_cur      = rem_ff[k-1];
            low_cur      = low_ff[k-1];
            quo_cur      = quo_ff[k-1];
            den_cur      = den_ff[k-1];
            interior_cur = interior_ff[k-1];
            alt_cur      = alt_ff[k-1];
         end
      end

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_cur, low_cur[DB-1]};
         ge     = trial >= {1'b0, den_cur};
         diff   = trial - {1'b0, den_cur};
         rem_in = ge ? diff[DB-1:0] : trial[DB-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]      <= rem_in;
            low_ff[k]      <= {low_cur[DB-2:0], 1'b0};
            quo_ff[k]      <= {quo_cur[DB-2:0], ge};
            den_ff[k]      <= den_cur;
            interior_ff[k] <= interior_cur;
            alt_ff[k]      <= alt_cur;
         end
      end
   end

   assign quo          = quo_ff[DB-1];
   assign interior_out = interior_ff[DB-1];
   assign alt_out      = alt_ff[DB-1];

endmodule

>>> rtl/spmd_lane.sv
// spmd_lane: squared distance from one point to one segment, fully pipelined
// uses spmd_div for the interior case; no package use
module spmd_lane #(
   parameter int COORD_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [COORD_BITS-1:0] sx,
   input  logic signed [COORD_BITS-1:0] sy,
   input  logic signed [COORD_BITS-1:0] ex,
   input  logic signed [COORD_BITS-1:0] ey,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output logic [2*COORD_BITS:0]        dist_sq
);

   localparam int C  = COORD_BITS;
   localparam int D  = C + 1;
   localparam int P  = 2 * D;
   localparam int DB = 2 * C + 1;
   localparam int H  = (DB + 1) / 2;
   localparam int HB = DB - H;

   // stage 1: differences
   logic signed [D-1:0] wx_ff, wy_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= {ex[C-1], ex} - {sx[C-1], sx};
         wy_ff <= {ey[C-1], ey} - {sy[C-1], sy};
         qx_ff <= {px[C-1], px} - {sx[C-1], sx};
         qy_ff <= {py[C-1], py} - {sy[C-1], sy};
         rx_ff <= {px[C-1], px} - {ex[C-1], ex};
         ry_ff <= {py[C-1], py} - {ey[C-1], ey};
      end
   end

   // stage 2: products
   logic signed [P-1:0] wxwx_ff, wywy_ff, qxwx_ff, qywy_ff, qxwy_ff, qywx_ff;
   logic signed [P-1:0] qxqx_ff, qyqy_ff, rxrx_ff, ryry_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wxwx_ff <= wx_ff * wx_ff;
         wywy_ff <= wy_ff * wy_ff;
         qxwx_ff <= qx_ff * wx_ff;
         qywy_ff <= qy_ff * wy_ff;
         qxwy_ff <= qx_ff * wy_ff;
         qywx_ff <= qy_ff * wx_ff;
         qxqx_ff <= qx_ff * qx_ff;
         qyqy_ff <= qy_ff * qy_ff;
         rxrx_ff <= rx_ff * rx_ff;
         ryry_ff <= ry_ff * ry_ff;
      end
   end

   // stage 3: length, dot, cross and the two endpoint distances
   logic signed [P:0] l2_in, dot_in, cross_in, qn_in, rn_in;
   logic [DB-1:0]     l2_ff, qn_ff, rn_ff;
   logic signed [P:0] dot_ff, cross_ff;
   always_comb begin
      l2_in    = {wxwx_ff[P-1], wxwx_ff} + {wywy_ff[P-1], wywy_ff};
      dot_in   = {qxwx_ff[P-1], qxwx_ff} + {qywy_ff[P-1], qywy_ff};
      cross_in = {qxwy_ff[P-1], qxwy_ff} - {qywx_ff[P-1], qywx_ff};
      qn_in    = {qxqx_ff[P-1], qxqx_ff} + {qyqy_ff[P-1], qyqy_ff};
      rn_in    = {rxrx_ff[P-1], rxrx_ff} + {ryry_ff[P-1], ryry_ff};
   end
   always_ff @(posedge clock) begin
      if (en) begin
         l2_ff    <= l2_in[DB-1:0];
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
         qn_ff    <= qn_in[DB-1:0];
         rn_ff    <= rn_in[DB-1:0];
      end
   end

   // stage 4: pick the case, take the cross magnitude
   logic              zero_len, before_start, past_end;
   logic signed [P:0] cross_neg;
   logic [DB-1:0]     mag_ff, l2b_ff, alt4_ff;
   logic              inside4_ff;
   always_comb begin
      zero_len     = l2_ff == '0;
      before_start = dot_ff[P] || dot_ff == '0;
      past_end     = dot_ff >= $signed({2'b00, l2_ff});
      cross_neg    = -cross_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= cross_ff[P] ? cross_neg[DB-1:0] : cross_ff[DB-1:0];
         l2b_ff     <= zero_len ? {{(DB-1){1'b0}}, 1'b1} : l2_ff;
         alt4_ff    <= (zero_len || before_start) ? qn_ff : rn_ff;
         inside4_ff <= !(zero_len || before_start || past_end);
      end
   end

   // stage 5: square the cross magnitude in halves
   logic [2*H-1:0]  ll_ff;
   logic [H+HB-1:0] lh_ff;
   logic [2*HB-1:0] hh_ff;
   logic [DB-1:0]   l2c_ff, alt5_ff;
   logic            inside5_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff      <= mag_ff[H-1:0] * mag_ff[H-1:0];
         lh_ff      <= mag_ff[H-1:0] * mag_ff[DB-1:H];
         hh_ff      <= mag_ff[DB-1:H] * mag_ff[DB-1:H];
         l2c_ff     <= l2b_ff;
         alt5_ff    <= alt4_ff;
         inside5_ff <= inside4_ff;
      end
   end

   // stage 6: assemble the dividend
   logic [2*DB-1:0] num_ff;
   logic [DB-1:0]   den_ff, alt6_ff;
   logic            inside6_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff     <= ({{(2*DB-2*HB){1'b0}}, hh_ff} << (2*H))
                     + ({{(2*DB-H-HB){1'b0}}, lh_ff} << (H+1))
                     + {{(2*DB-2*H){1'b0}}, ll_ff};
         den_ff     <= l2c_ff;
         alt6_ff    <= alt5_ff;
         inside6_ff <= inside5_ff;
      end
   end

   logic [DB-1:0] quo, alt_d;
   logic          inside_d;

   spmd_div #(.DIST_BITS(DB)) u_div (
      .clock        (clock),
      .en           (en),
      .num          (num_ff),
      .den          (den_ff),
      .interior     (inside6_ff),
      .alt          (alt6_ff),
      .quo          (quo),
      .interior_out (inside_d),
      .alt_out      (alt_d)
   );

   // final: interior quotient or endpoint distance
   logic [DB-1:0] dist_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= inside_d ? quo : alt_d;
      end
   end
   assign dist_sq = dist_ff;

endmodule

>>> rtl/spmd_merge.sv
// spmd_merge: registered two-level minimum over the lane distances
// depends on spmd_pkg for the lane count and roles
module spmd_merge #(
   parameter int DIST_BITS = 33
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [DIST_BITS-1:0] lane_dist [spmd_pkg::NUM_LANES],
   output logic [DIST_BITS-1:0] best
);

   logic [DIST_BITS-1:0] pair_a_ff, pair_b_ff, best_ff;
   logic [DIST_BITS-1:0] a1, a2, b1, b2;

   always_comb begin
      a1 = lane_dist[spmd_pkg::LANE_A1_TO_B];
      a2 = lane_dist[spmd_pkg::LANE_A2_TO_B];
      b1 = lane_dist[spmd_pkg::LANE_B1_TO_A];
      b2 = lane_dist[spmd_pkg::LANE_B2_TO_A];
   end

   // first level: pairwise minimum
   always_ff @(posedge clock) begin
      if (en) begin
         pair_a_ff <= (a2 < a1) ? a2 : a1;
         pair_b_ff <= (b2 < b1) ? b2 : b1;
      end
   end

   // second level: overall minimum, drives the result word
   always_ff @(posedge clock) begin
      if (en) begin
         best_ff <= (pair_b_ff < pair_a_ff) ? pair_b_ff : pair_a_ff;
      end
   end
   assign best = best_ff;

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for segment_pair_min_distance_sq
// depends on the rtl top level; holds its own distance predictor and result checker
module testbench;

   localparam int CB = 16;
   localparam int DB = 2 * CB + 1;
   localparam int LATENCY = 2 * CB + 10;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct packed {
      coord_type ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   } seg_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_type req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DB-1:0] rsp_min_dist_sq;

   logic [DB-1:0] dist_expected_q[$];
   int error_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   longint cycle_count = 0;
   bit sender_bursty = 1'b1;

   segment_pair_min_distance_sq #(.COORD_BITS(CB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_min_dist_sq(rsp_min_dist_sq)
   );

   // clock, 12 units
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // squared distance from point p to segment s-e, exact integer math
   function automatic logic [127:0] point_seg_dist(longint sx, longint sy, longint ex,
                                                   longint ey, longint px, longint py);
      longint wx, wy, qx, qy, dot, crs;
      logic [127:0] l2, cross_sq;
      wx = ex - sx; wy = ey - sy;
      qx = px - sx; qy = py - sy;
      l2 = wx * wx + wy * wy;
      if (l2 == 0) return qx * qx + qy * qy;
      dot = qx * wx + qy * wy;
      if (dot <= 0) return qx * qx + qy * qy;
      if (dot >= l2) return (px - ex) * (px - ex) + (py - ey) * (py - ey);
      crs = qx * wy - qy * wx;
      if (crs < 0) crs = -crs;
      cross_sq = 128'(crs) * 128'(crs);
      return cross_sq / l2;
   endfunction

   // smallest of the four endpoint-to-segment distances, saturated to DB bits
   function automatic logic [DB-1:0] min_endpoint_dist(seg_pair_type p);
      logic [127:0] best, d;
      best = point_seg_dist(p.bx1, p.by1, p.bx2, p.by2, p.ax1, p.ay1);
      d = point_seg_dist(p.bx1, p.by1, p.bx2, p.by2, p.ax2, p.ay2);
      if (d < best) best = d;
      d = point_seg_dist(p.ax1, p.ay1, p.ax2, p.ay2, p.bx1, p.by1);
      if (d < best) best = d;
      d = point_seg_dist(p.ax1, p.ay1, p.ax2, p.ay2, p.bx2, p.by2);
      if (d < best) best = d;
      if (best > {DB{1'b1}}) best = {DB{1'b1}};
      return best[DB-1:0];
   endfunction

   // send one word, hold it until accepted, then maybe leave a gap
   task automatic send_pair(seg_pair_type p);
      req_a_start_x <= p.ax1; req_a_start_y <= p.ay1;
      req_a_end_x <= p.ax2; req_a_end_y <= p.ay2;
      req_b_start_x <= p.bx1; req_b_start_y <= p.by1;
      req_b_end_x <= p.bx2; req_b_end_y <= p.by2;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      dist_expected_q.push_back(min_endpoint_dist(p));
      words_sent++;
      @(negedge clock);
      if (sender_bursty && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 4))
         0: return coord_type'(int'($urandom_range(0, 7)) - 4);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic seg_pair_type rand_pair();
      seg_pair_type p;
      coord_type base;
      p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // sometimes a small local cluster in x so the interior projection case gets hit
      if ($urandom_range(0, 2) == 0) begin
         base = coord_type'($urandom);
         p.ax1 = base + coord_type'($urandom_range(0, 200));
         p.ax2 = base + coord_type'($urandom_range(0, 200));
         p.bx1 = base + coord_type'($urandom_range(0, 200));
         p.bx2 = base + coord_type'($urandom_range(0, 200));
      end
      return p;
   endfunction

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dist_expected_q.size() == 0) begin
            $display("%0t: unexpected word, actual %0d", $time, rsp_min_dist_sq);
            error_count++;
         end else begin
            if (rsp_min_dist_sq !== dist_expected_q[0]) begin
               $display("%0t: min_dist_sq mismatch, expected %0d, actual %0d",
                        $time, dist_expected_q[0], rsp_min_dist_sq);
               error_count++;
            end
            void'(dist_expected_q.pop_front());
            words_checked++;
         end
      end
   end

   // receiver stall pattern, with quiet stretches
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if ((cycle_count / 300) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // extreme coordinates and degenerate segments
   task automatic test_extremes();
      send_pair('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      send_pair('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_pair('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
      send_pair('{-1, -1, -1, -1, 0, 0, 0, 0});
      send_pair('{16'sh8000, 0, 16'sh7fff, 0, 0, 16'sh8000, 0, 16'sh7fff});
   endtask

   // projection before start, past end, inside, zero length, crossing
   task automatic test_projection_cases();
      send_pair('{0, 0, 10, 0, -5, 3, -9, 7});
      send_pair('{0, 0, 10, 0, 14, 3, 20, 9});
      send_pair('{0, 0, 10, 0, 3, 5, 7, 9});
      send_pair('{0, 0, 10, 0, 3, 5, 3, 5});
      send_pair('{0, 0, 10, 10, 0, 10, 10, 0});
      send_pair('{0, 0, 7, 3, 2, 5, 9, 11});
      send_pair('{0, 0, 10, 0, 10, 4, 12, 4});
      send_pair('{0, 0, 10, 0, 0, 4, -3, 4});
      send_pair('{-100, 50, 300, -70, 20, 40, 5, 300});
      send_pair('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1, -1, 100, -120});
   endtask

   // random words, sender in bursts
   task automatic test_random(int count);
      repeat (count) send_pair(rand_pair());
   endtask

   // back-to-back words without sender gaps
   task automatic test_back_to_back(int count);
      sender_bursty = 1'b0;
      repeat (count) send_pair(rand_pair());
      sender_bursty = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_projection_cases();
      test_random(500);
      test_back_to_back(150);
      req_valid <= 1'b0;
      wait (dist_expected_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d words, checked %0d results over extremes, projection cases,",
               words_sent, words_checked);
      $display("random and back-to-back traffic with receiver stalls");
      if (error_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule

>>> segment_pair_min_distance_sq.f
rtl/spmd_pkg.sv
rtl/spmd_div.sv
rtl/spmd_lane.sv
rtl/spmd_merge.sv
rtl/segment_pair_min_distance_sq.sv
tb/testbench.sv
